// ===== hw/rtl/kvrsp_pkg.sv =====
// Package for the key/value record stream parser.
// Holds the parse phase, byte role and final status codes and the header constants.
// No dependencies.
package kvrsp_pkg;

    localparam int HEADER_BYTES    = 16;
    localparam int WORD_BYTES      = 4;
    localparam int SIZE_WORD_INDEX = 12 / WORD_BYTES;
    localparam int CFG_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 1;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_KEY    = 3'd2,
        PH_VALUE  = 3'd3,
        PH_PAD    = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_LENGTH  = 3'd1,
        ROLE_KEY     = 3'd2,
        ROLE_VALUE   = 3'd3,
        ROLE_PAD     = 3'd4,
        ROLE_IGNORED = 3'd5
    } role_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_OVERRUN     = 3'd4,
        ST_TRUNCATED   = 3'd5
    } status_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MAGIC   = 1'b0,
        CFG_VERSION = 1'b1
    } cfg_index_t;

endpackage

// ===== hw/rtl/kvrsp_if.sv =====
// Stream interfaces for the key/value record stream parser.
// Input byte channel and tagged result channel.
interface kvrsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface kvrsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] byte_role;
    logic       entry_done;
    logic       final_valid;
    logic [2:0] final_status;

    modport source (output valid, output byte_out, output byte_role, output entry_done,
                    output final_valid, output final_status, input ready);
    modport sink   (input valid, input byte_out, input byte_role, input entry_done,
                    input final_valid, input final_status, output ready);
endinterface

// ===== hw/rtl/key_value_record_stream_parser.sv =====
// Key/value record stream parser, top level.
// Uses kvrsp_pkg and the interfaces in kvrsp_if.sv.
//
// Takes one buffer byte per transaction and returns one tagged result per byte
// through the output register. A new byte is taken every cycle while the output
// side accepts or the output register is empty, so throughput is one byte per
// clock; the per-byte work is a counter update and a few 32-bit compares. A byte with
// last_byte set carries the final status and resets the parse state for the next
// buffer. The user must write expected_magic (index 0) and expected_version (index 1)
// through the cfg port only while the block is idle; the block does not enforce this.
module key_value_record_stream_parser #(
    parameter int HEADER_BYTES = kvrsp_pkg::HEADER_BYTES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [kvrsp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [kvrsp_pkg::CFG_WIDTH-1:0]       cfg_data,
    kvrsp_in_if.sink                              in_ch,
    kvrsp_out_if.source                           out_ch
);

    logic [31:0]       magic_reg;
    logic [31:0]       version_reg;

    kvrsp_pkg::phase_t phase_reg, phase_next;
    logic [31:0]       pos_reg, pos_next;
    logic              wrapped_reg, wrapped_next;
    logic [31:0]       hdr_reg [4];
    logic [31:0]       hdr_next [4];
    logic [1:0]        len_idx_reg, len_idx_next;
    logic [15:0]       key_rem_reg, key_rem_next;
    logic [15:0]       val_rem_reg, val_rem_next;
    logic [31:0]       entries_reg, entries_next;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    kvrsp_pkg::role_t  out_role_reg;
    logic              out_done_reg;
    logic              out_final_reg;
    kvrsp_pkg::status_t out_status_reg;

    logic              accept;
    logic [7:0]        b;
    logic [31:0]       ent_inc;
    kvrsp_pkg::phase_t after_entry;
    logic [32:0]       length;
    logic [32:0]       needed;
    kvrsp_pkg::role_t  role;
    logic              done;
    kvrsp_pkg::status_t status;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.data_byte;
    assign ent_inc     = entries_reg + 32'd1;
    assign after_entry = (pos_reg[1:0] != 2'd3) ? kvrsp_pkg::PH_PAD :
                         ((ent_inc < hdr_reg[2]) ? kvrsp_pkg::PH_LENGTH : kvrsp_pkg::PH_DONE);

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        len_idx_next = len_idx_reg;
        key_rem_next = key_rem_reg;
        val_rem_next = val_rem_reg;
        entries_next = entries_reg;
        for (int i = 0; i < 4; i++)
        begin
            hdr_next[i] = hdr_reg[i];
        end
        case (phase_reg)
            kvrsp_pkg::PH_HEADER:
            begin
                if (pos_reg[31:4] == 28'd0)
                begin
                    hdr_next[pos_reg[3:2]] = hdr_reg[pos_reg[3:2]]
                                           | ({24'd0, b} << {pos_reg[1:0], 3'b000});
                end
                if (pos_reg == 32'(HEADER_BYTES - 1))
                begin
                    if (hdr_next[0] != magic_reg || hdr_next[1] != version_reg
                        || hdr_next[2] == 32'd0)
                    begin
                        phase_next = kvrsp_pkg::PH_DONE;
                    end
                    else
                    begin
                        phase_next = kvrsp_pkg::PH_LENGTH;
                    end
                end
            end
            kvrsp_pkg::PH_LENGTH:
            begin
                case (len_idx_reg)
                    2'd0:    key_rem_next = {key_rem_reg[15:8], b};
                    2'd1:    key_rem_next = {b, key_rem_reg[7:0]};
                    2'd2:    val_rem_next = {val_rem_reg[15:8], b};
                    default: val_rem_next = {b, val_rem_reg[7:0]};
                endcase
                len_idx_next = len_idx_reg + 2'd1;
                if (len_idx_reg == 2'd3)
                begin
                    if (key_rem_next != 16'd0)
                    begin
                        phase_next = kvrsp_pkg::PH_KEY;
                    end
                    else if (val_rem_next != 16'd0)
                    begin
                        phase_next = kvrsp_pkg::PH_VALUE;
                    end
                    else
                    begin
                        entries_next = ent_inc;
                        phase_next   = after_entry;
                    end
                end
            end
            kvrsp_pkg::PH_KEY:
            begin
                key_rem_next = key_rem_reg - 16'd1;
                if (key_rem_next == 16'd0)
                begin
                    if (val_rem_reg != 16'd0)
                    begin
                        phase_next = kvrsp_pkg::PH_VALUE;
                    end
                    else
                    begin
                        entries_next = ent_inc;
                        phase_next   = after_entry;
                    end
                end
            end
            kvrsp_pkg::PH_VALUE:
            begin
                val_rem_next = val_rem_reg - 16'd1;
                if (val_rem_next == 16'd0)
                begin
                    entries_next = ent_inc;
                    phase_next   = after_entry;
                end
            end
            kvrsp_pkg::PH_PAD:
            begin
                if (pos_reg[1:0] == 2'd3)
                begin
                    phase_next = (entries_reg < hdr_reg[2]) ? kvrsp_pkg::PH_LENGTH
                                                            : kvrsp_pkg::PH_DONE;
                end
            end
            default:
            begin
                phase_next = kvrsp_pkg::PH_DONE;
            end
        endcase
        pos_next     = pos_reg + 32'd1;
        wrapped_next = wrapped_reg || (pos_reg == 32'hFFFF_FFFF);
    end

    // result fields
    always_comb
    begin
        role = kvrsp_pkg::ROLE_IGNORED;
        done = 1'b0;
        case (phase_reg)
            kvrsp_pkg::PH_HEADER: role = kvrsp_pkg::ROLE_HEADER;
            kvrsp_pkg::PH_LENGTH:
            begin
                role = kvrsp_pkg::ROLE_LENGTH;
                done = (len_idx_reg == 2'd3) && (key_rem_reg == 16'd0)
                       && ({b, val_rem_reg[7:0]} == 16'd0);
            end
            kvrsp_pkg::PH_KEY:
            begin
                role = kvrsp_pkg::ROLE_KEY;
                done = (key_rem_reg == 16'd1) && (val_rem_reg == 16'd0);
            end
            kvrsp_pkg::PH_VALUE:
            begin
                role = kvrsp_pkg::ROLE_VALUE;
                done = (val_rem_reg == 16'd1);
            end
            kvrsp_pkg::PH_PAD: role = kvrsp_pkg::ROLE_PAD;
            default:           role = kvrsp_pkg::ROLE_IGNORED;
        endcase

        length = {1'b0, pos_reg} + 33'd1;
        needed = {1'b0, hdr_next[kvrsp_pkg::SIZE_WORD_INDEX]}
               + 33'(HEADER_BYTES);
        if (!in_ch.last_byte)
        begin
            status = kvrsp_pkg::ST_OK;
        end
        else if (!wrapped_next && length < 33'(HEADER_BYTES))
        begin
            status = kvrsp_pkg::ST_TOO_SHORT;
        end
        else if (hdr_next[0] != magic_reg)
        begin
            status = kvrsp_pkg::ST_BAD_MAGIC;
        end
        else if (hdr_next[1] != version_reg)
        begin
            status = kvrsp_pkg::ST_BAD_VERSION;
        end
        else if (!wrapped_next && needed > length)
        begin
            status = kvrsp_pkg::ST_OVERRUN;
        end
        else if (entries_next < hdr_next[2])
        begin
            status = kvrsp_pkg::ST_TRUNCATED;
        end
        else
        begin
            status = kvrsp_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= 32'd0;
            version_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kvrsp_pkg::CFG_MAGIC:   magic_reg   <= cfg_data;
                kvrsp_pkg::CFG_VERSION: version_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= kvrsp_pkg::PH_HEADER;
            pos_reg     <= 32'd0;
            wrapped_reg <= 1'b0;
            len_idx_reg <= 2'd0;
            key_rem_reg <= 16'd0;
            val_rem_reg <= 16'd0;
            entries_reg <= 32'd0;
            for (int i = 0; i < 4; i++)
            begin
                hdr_reg[i] <= 32'd0;
            end
        end
        else if (accept)
        begin
            if (in_ch.last_byte)
            begin
                phase_reg   <= kvrsp_pkg::PH_HEADER;
                pos_reg     <= 32'd0;
                wrapped_reg <= 1'b0;
                len_idx_reg <= 2'd0;
                key_rem_reg <= 16'd0;
                val_rem_reg <= 16'd0;
                entries_reg <= 32'd0;
                for (int i = 0; i < 4; i++)
                begin
                    hdr_reg[i] <= 32'd0;
                end
            end
            else
            begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                wrapped_reg <= wrapped_next;
                len_idx_reg <= len_idx_next;
                key_rem_reg <= key_rem_next;
                val_rem_reg <= val_rem_next;
                entries_reg <= entries_next;
                for (int i = 0; i < 4; i++)
                begin
                    hdr_reg[i] <= hdr_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg   <= b;
            out_role_reg   <= role;
            out_done_reg   <= done;
            out_final_reg  <= in_ch.last_byte;
            out_status_reg <= status;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.byte_out     = out_byte_reg;
    assign out_ch.byte_role    = out_role_reg;
    assign out_ch.entry_done   = out_done_reg;
    assign out_ch.final_valid  = out_final_reg;
    assign out_ch.final_status = out_status_reg;

endmodule
